// ===== design/bplp_pkg.sv =====
package bplp_pkg;

  localparam int BTN_CNT   = 8;
  localparam int IDX_W     = 3;
  localparam int TICK_W    = 32;
  localparam int THR_W     = 16;
  localparam int MAP_W     = 24;
  localparam int CFG_IDX_W = 8;

  localparam logic [THR_W-1:0] THR_RESET = 16'd500;
  localparam logic [MAP_W-1:0] MAP_RESET = 24'hFAC688;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_MAP    = 8'd1;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LONG    = 2'd2
  } kind_t;

  typedef struct packed {
    logic  vld;
    kind_t kind;
  } lane_evt_t;

endpackage

// ===== design/button_press_long_press_detector.sv =====
// Button press and long-press detector. Each input transaction is one poll of
// an active-low 8-bit button port plus the current 32-bit tick. Every button
// has its own lane that compares its mapped port bit with the stored level and
// checks the held time against long_press_ticks (wrapping subtraction,
// strictly greater). A poll is evaluated in the cycle it is accepted and yields
// 0 to 8 events (press, release or long press), which leave one per cycle in
// button order while out_tready does not stall the output, the final one
// flagged by out_tlast. The next poll is taken in the cycle the last pending
// event moves to the output register, and a poll without events does not hold
// off the next one. Configuration writes are always accepted and must only be
// issued while the block is idle.
module button_press_long_press_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] port_bits, [39:8] now_tick
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] button_index, [7:3] zero
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast,  // last_event
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import bplp_pkg::*;

  logic [THR_W-1:0]  thr_r;
  logic [MAP_W-1:0]  map_r;
  logic [7:0]        port_bits;
  logic [TICK_W-1:0] now_tick;
  logic              accept;
  lane_evt_t         lane_evt [BTN_CNT];
  logic [IDX_W-1:0]  out_idx;
  kind_t             out_kind;

  assign cfg_ready = 1'b1;
  assign port_bits = in_tdata[7:0];
  assign now_tick  = in_tdata[39:8];
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      map_r <= MAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LONG_TICKS: thr_r <= cfg_data[THR_W-1:0];
        REG_PIN_MAP:    map_r <= cfg_data[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < BTN_CNT; g++) begin : g_lane
    bplp_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .accept    (accept),
      .port_bits (port_bits),
      .now_tick  (now_tick),
      .pin_sel   (map_r[3*g +: 3]),
      .thr       (thr_r),
      .evt       (lane_evt[g])
    );
  end

  bplp_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .lane_evt (lane_evt),
    .in_vld   (in_tvalid),
    .in_rdy   (in_tready),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_idx  (out_idx),
    .out_kind (out_kind),
    .out_last (out_tlast)
  );

  assign out_tdata = {{(8-IDX_W){1'b0}}, out_idx};
  assign out_tuser = out_kind;

endmodule

// ===== design/bplp_lane.sv =====
module bplp_lane (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [7:0]                   port_bits,
  input  logic [bplp_pkg::TICK_W-1:0]  now_tick,
  input  logic [2:0]                   pin_sel,
  input  logic [bplp_pkg::THR_W-1:0]   thr,
  output bplp_pkg::lane_evt_t          evt
);
  import bplp_pkg::*;

  logic              level_r, level_nxt;
  logic              fired_r, fired_nxt;
  logic [TICK_W-1:0] start_r, start_nxt;
  logic              lvl;
  logic              changed;
  logic [TICK_W-1:0] held;
  logic              long_hit;

  assign lvl      = port_bits[pin_sel];
  assign changed  = (lvl != level_r);
  assign held     = now_tick - start_r;
  assign long_hit = !changed && !level_r && !fired_r &&
                    (held > {{(TICK_W-THR_W){1'b0}}, thr});

  always_comb begin
    evt.vld   = changed || long_hit;
    evt.kind  = changed ? (lvl ? KIND_RELEASE : KIND_PRESS) : KIND_LONG;
    level_nxt = level_r;
    fired_nxt = fired_r;
    start_nxt = start_r;
    if (accept) begin
      if (changed) begin
        level_nxt = lvl;
        if (!lvl) begin
          start_nxt = now_tick;
          fired_nxt = 1'b0;
        end
      end else if (long_hit) begin
        fired_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b1;
      fired_r <= 1'b0;
      start_r <= '0;
    end else begin
      level_r <= level_nxt;
      fired_r <= fired_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// ===== design/bplp_merge.sv =====
module bplp_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bplp_pkg::lane_evt_t        lane_evt [bplp_pkg::BTN_CNT],
  input  logic                       in_vld,
  output logic                       in_rdy,
  output logic                       out_vld,
  input  logic                       out_rdy,
  output logic [bplp_pkg::IDX_W-1:0] out_idx,
  output bplp_pkg::kind_t            out_kind,
  output logic                       out_last
);
  import bplp_pkg::*;

  logic [BTN_CNT-1:0] mask_r, mask_nxt;
  kind_t              kind_r [BTN_CNT];
  logic [BTN_CNT-1:0] sel_hot;
  logic [IDX_W-1:0]   sel_idx;
  logic               sel_last;
  logic               move;
  logic               accept;
  logic               ovld_r, ovld_nxt;
  logic [IDX_W-1:0]   oidx_r;
  kind_t              okind_r;
  logic               olast_r;

  always_comb begin
    sel_idx = '0;
    for (int i = BTN_CNT - 1; i >= 0; i--) begin
      if (mask_r[i]) sel_idx = IDX_W'(i);
    end
  end

  assign sel_hot  = mask_r & (~mask_r + 1'b1);
  assign sel_last = ((mask_r & ~sel_hot) == '0);
  assign move     = (|mask_r) && (!ovld_r || out_rdy);
  // Take a new poll once the pending set is empty or drains this cycle.
  assign in_rdy   = (mask_r == '0) || (move && sel_last);
  assign accept   = in_vld && in_rdy;

  always_comb begin
    mask_nxt = mask_r;
    if (accept) begin
      for (int i = 0; i < BTN_CNT; i++) mask_nxt[i] = lane_evt[i].vld;
    end else if (move) begin
      mask_nxt = mask_r & ~sel_hot;
    end
    ovld_nxt = ovld_r;
    if (move) ovld_nxt = 1'b1;
    else if (out_rdy) ovld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < BTN_CNT; i++) kind_r[i] <= lane_evt[i].kind;
    end
    if (move) begin
      oidx_r  <= sel_idx;
      okind_r <= kind_r[sel_idx];
      olast_r <= sel_last;
    end
  end

  assign out_vld  = ovld_r;
  assign out_idx  = oidx_r;
  assign out_kind = okind_r;
  assign out_last = olast_r;

endmodule

// ===== design/bplp_checker.sv =====
module bplp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import bplp_pkg::*;

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:3] == 5'd0)
    else $error("tdata padding not zero");

  // Events of one poll follow without gaps, in rising button order.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[2:0] > $past(out_tdata[2:0])))
    else $error("events of a poll out of order or interrupted");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind button_press_long_press_detector bplp_checker u_bplp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
